// ===== sv/g2h_pkg.sv =====
// Shared types, constants and helpers for the Gregorian to Hijri date converter.
package g2h_pkg;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_hijri;

    localparam logic [13:0] YEAR_BIAS = 14'd4800;
    // -32045 (civil epoch) - 1948440 + 10632 (Islamic epoch) - 1 (cycle split)
    localparam int DN_BIAS = -1969854;
    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned CYCLE_OFS   = 355;
    localparam int unsigned YIN_A_OFS   = 10985;
    localparam int unsigned MUL_A2      = 50;
    localparam int unsigned MUL_B2      = 43;
    localparam int unsigned C1_OFS      = 30;
    localparam int unsigned MUL_C2      = 17719;
    localparam int unsigned MUL_D2      = 15238;
    localparam int unsigned MON_OFS     = 29;
    localparam int unsigned MUL_MON     = 24;
    localparam int unsigned YEARS_CYCLE = 30;

    // Constant division by reciprocal: for x < 2**NB, q = (x * M) >> S is exact
    // with S = NB + clog2(D) and M = ceil(2**S / D).
    localparam longint unsigned DIV_CENT = 25;
    localparam int unsigned NB_CENT = 12;
    localparam int unsigned S_CENT = NB_CENT + $clog2(DIV_CENT);
    localparam longint unsigned M_CENT = ((64'd1 << S_CENT) + DIV_CENT - 1) / DIV_CENT;

    localparam longint unsigned DIV_CYC = 10631;
    localparam int unsigned NB_CYC = 21;
    localparam int unsigned S_CYC = NB_CYC + $clog2(DIV_CYC);
    localparam longint unsigned M_CYC = ((64'd1 << S_CYC) + DIV_CYC - 1) / DIV_CYC;

    localparam longint unsigned DIV_A1 = 5316;
    localparam int unsigned NB_A1 = 15;
    localparam int unsigned S_A1 = NB_A1 + $clog2(DIV_A1);
    localparam longint unsigned M_A1 = ((64'd1 << S_A1) + DIV_A1 - 1) / DIV_A1;

    localparam longint unsigned DIV_A2 = 17719;
    localparam int unsigned NB_A2 = 20;
    localparam int unsigned S_A2 = NB_A2 + $clog2(DIV_A2);
    localparam longint unsigned M_A2 = ((64'd1 << S_A2) + DIV_A2 - 1) / DIV_A2;

    localparam longint unsigned DIV_B1 = 5670;
    localparam int unsigned NB_B1 = 14;
    localparam int unsigned S_B1 = NB_B1 + $clog2(DIV_B1);
    localparam longint unsigned M_B1 = ((64'd1 << S_B1) + DIV_B1 - 1) / DIV_B1;

    localparam longint unsigned DIV_B2 = 15238;
    localparam int unsigned NB_B2 = 19;
    localparam int unsigned S_B2 = NB_B2 + $clog2(DIV_B2);
    localparam longint unsigned M_B2 = ((64'd1 << S_B2) + DIV_B2 - 1) / DIV_B2;

    localparam longint unsigned DIV_C1 = 15;
    localparam int unsigned NB_C1 = 8;
    localparam int unsigned S_C1 = NB_C1 + $clog2(DIV_C1);
    localparam longint unsigned M_C1 = ((64'd1 << S_C1) + DIV_C1 - 1) / DIV_C1;

    localparam longint unsigned DIV_C2 = 50;
    localparam int unsigned NB_C2 = 22;
    localparam int unsigned S_C2 = NB_C2 + $clog2(DIV_C2);
    localparam longint unsigned M_C2 = ((64'd1 << S_C2) + DIV_C2 - 1) / DIV_C2;

    localparam longint unsigned DIV_D1 = 16;
    localparam int unsigned NB_D1 = 8;
    localparam int unsigned S_D1 = NB_D1 + $clog2(DIV_D1);
    localparam longint unsigned M_D1 = ((64'd1 << S_D1) + DIV_D1 - 1) / DIV_D1;

    localparam longint unsigned DIV_D2 = 43;
    localparam int unsigned NB_D2 = 21;
    localparam int unsigned S_D2 = NB_D2 + $clog2(DIV_D2);
    localparam longint unsigned M_D2 = ((64'd1 << S_D2) + DIV_D2 - 1) / DIV_D2;

    localparam longint unsigned DIV_MON = 709;
    localparam int unsigned NB_MON = 26;
    localparam int unsigned S_MON = NB_MON + $clog2(DIV_MON);
    localparam longint unsigned M_MON = ((64'd1 << S_MON) + DIV_MON - 1) / DIV_MON;

    localparam longint unsigned DIV_DAY = 24;
    localparam int unsigned NB_DAY = 26;
    localparam int unsigned S_DAY = NB_DAY + $clog2(DIV_DAY);
    localparam longint unsigned M_DAY = ((64'd1 << S_DAY) + DIV_DAY - 1) / DIV_DAY;

    function automatic logic [31:0] mul_shr(input logic [31:0] x, input logic [31:0] m,
                                            input int unsigned s);
        logic [63:0] p;
        p = {32'd0, x} * {32'd0, m};
        return 32'(p >> s);
    endfunction

    // January and February count as months 11 and 12 of the previous year
    function automatic logic month_early(input logic [3:0] mo);
        return (mo <= 4'd2);
    endfunction

    // (153 * mm + 2) / 5 with mm the March-based month
    function automatic logic [8:0] month_term(input logic [3:0] mo);
        logic [8:0] t;
        unique case (mo)
            4'd0:    t = 9'd275;
            4'd1:    t = 9'd306;
            4'd2:    t = 9'd337;
            4'd3:    t = 9'd0;
            4'd4:    t = 9'd31;
            4'd5:    t = 9'd61;
            4'd6:    t = 9'd92;
            4'd7:    t = 9'd122;
            4'd8:    t = 9'd153;
            4'd9:    t = 9'd184;
            4'd10:   t = 9'd214;
            4'd11:   t = 9'd245;
            4'd12:   t = 9'd275;
            4'd13:   t = 9'd306;
            4'd14:   t = 9'd337;
            4'd15:   t = 9'd367;
            default: t = 9'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== sv/gregorian_to_hijri_date_core.sv =====
// Gregorian to tabular Islamic date converter: 17-stage pipeline with output skid.
// Stage 1 loads at the accepting edge; results pass stages 2 to 17, then the output register.
// Throughput: one request per cycle while o_stall is low; each constant division is one
// reciprocal multiply stage, so the chain of dependent divisions sets the depth, not the rate.
// A result held by i_stall parks in the output register and a one-entry skid.
// Reset (synchronous, active low) empties the pipeline and clears day_correction to 0.
module gregorian_to_hijri_date_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic signed [5:0] i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [11:0]       i_greg_year,
    input  logic [3:0]        i_greg_month,
    input  logic [4:0]        i_greg_day,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [11:0]       o_hijri_year,
    output logic [3:0]        o_hijri_month,
    output logic [4:0]        o_hijri_day
);

    localparam int NST = 17;

    logic              [NST:1] r_vld;
    logic                      r_o_v, n_o_v;
    logic                      r_sk_v, n_sk_v;
    logic signed [5:0]         r_corr;
    g2h_pkg::t_hijri           r_out, r_skid, n_res;
    logic                      adv, take, load_out, load_skid, out_from_skid;

    // stage 1: month table, shifted year
    logic [13:0] n1_yy, r1_yy;
    logic [8:0]  n1_md, r1_md;
    // stage 2: century terms and 365 * yy
    logic [21:0] n2_p365, r2_p365;
    logic [11:0] n2_y4, r2_y4;
    logic [6:0]  n2_q100, r2_q100;
    logic [4:0]  n2_q400, r2_q400;
    logic [8:0]  r2_md;
    // stage 3: day number relative to the Islamic epoch, minus one
    logic signed [23:0] sum3;
    logic signed [21:0] n3_t, r3_t;
    // stage 4: sign / magnitude
    logic        n4_neg, r4_neg;
    logic [20:0] n4_mag, r4_mag;
    // stage 5: 30-year cycle count
    logic [6:0]  n5_qc, r5_qc;
    logic [20:0] r5_mag;
    logic        r5_neg;
    // stage 6: day within the cycle
    logic [13:0]        rmag6;
    logic signed [7:0]  n6_cyc, r6_cyc;
    logic signed [14:0] n6_rem2, r6_rem2;
    // stage 7: year-in-cycle numerators
    logic               n7_s, r7_s;
    logic [13:0]        n7_rabs, r7_rabs;
    logic [14:0]        n7_na1, r7_na1;
    logic [19:0]        n7_na2, r7_na2;
    logic [18:0]        n7_nb2, r7_nb2;
    logic signed [14:0] r7_rem2;
    logic signed [7:0]  r7_cyc;
    // stage 8: year-in-cycle quotients
    logic [1:0]         n8_qa1, r8_qa1;
    logic [4:0]         n8_qa2, r8_qa2;
    logic               n8_qb1, r8_qb1;
    logic [4:0]         n8_qb2, r8_qb2;
    logic               r8_s;
    logic signed [14:0] r8_rem2;
    logic signed [7:0]  r8_cyc;
    // stage 9: year in cycle
    logic [6:0]         pa9;
    logic [4:0]         pb9;
    logic signed [7:0]  n9_yin, r9_yin;
    logic signed [14:0] r9_rem2;
    logic signed [7:0]  r9_cyc;
    // stage 10: day-of-year numerators, final year
    logic signed [8:0]  c1v10;
    logic               n10_ys, r10_ys;
    logic               n10_c1neg, r10_c1neg;
    logic [6:0]         n10_yabs, r10_yabs;
    logic [7:0]         n10_nc1, r10_nc1;
    logic [21:0]        n10_nc2, r10_nc2;
    logic [20:0]        n10_nd2, r10_nd2;
    logic [11:0]        n10_hy, r10_hy;
    logic signed [14:0] r10_rem2;
    // stage 11: day-of-year quotients
    logic [3:0]         n11_qc1, r11_qc1;
    logic [15:0]        n11_qc2, r11_qc2;
    logic [2:0]         n11_qd1, r11_qd1;
    logic [15:0]        n11_qd2, r11_qd2;
    logic               r11_pcneg;
    logic signed [14:0] r11_rem2;
    logic [11:0]        r11_hy;
    // stage 12: year-length products
    logic [19:0]        n12_pc, r12_pc;
    logic [18:0]        n12_pd, r12_pd;
    logic               r12_pcneg;
    logic signed [14:0] r12_rem2;
    logic [11:0]        r12_hy;
    // stage 13: day of year
    logic signed [21:0] n13_rem3, r13_rem3;
    logic [11:0]        r13_hy;
    // stage 14: month numerator
    logic               n14_mneg, r14_mneg;
    logic [20:0]        rabs14;
    logic [25:0]        n14_nm, r14_nm;
    logic [4:0]         r14_rlo;
    logic [11:0]        r14_hy;
    // stage 15: month quotient
    logic [16:0]        n15_qm, r15_qm;
    logic               r15_mneg;
    logic [4:0]         r15_rlo;
    logic [11:0]        r15_hy;
    // stage 16: month start numerator
    logic [25:0]        n16_ndd, r16_ndd;
    logic [3:0]         n16_hm, r16_hm;
    logic               r16_mneg;
    logic [4:0]         r16_rlo;
    logic [11:0]        r16_hy;
    // stage 17: month start quotient
    logic [21:0]        n17_qdd, r17_qdd;
    logic [3:0]         r17_hm;
    logic               r17_mneg;
    logic [4:0]         r17_rlo;
    logic [11:0]        r17_hy;

    always_comb begin
        n1_yy = 14'(i_greg_year) + g2h_pkg::YEAR_BIAS
              - 14'(g2h_pkg::month_early(i_greg_month));
        n1_md = g2h_pkg::month_term(i_greg_month) + 9'(i_greg_day);

        // floor(yy/100) = floor(floor(yy/4)/25), same for 400 with yy/16
        n2_p365 = 22'(r1_yy) * 22'(g2h_pkg::DAYS_PER_YEAR);
        n2_y4   = r1_yy[13:2];
        n2_q100 = 7'(g2h_pkg::mul_shr(32'(r1_yy[13:2]), 32'(g2h_pkg::M_CENT),
                                      g2h_pkg::S_CENT));
        n2_q400 = 5'(g2h_pkg::mul_shr(32'(r1_yy[13:4]), 32'(g2h_pkg::M_CENT),
                                      g2h_pkg::S_CENT));

        sum3 = $signed({2'b00, r2_p365}) + $signed({12'd0, r2_y4})
             - $signed({17'd0, r2_q100}) + $signed({19'd0, r2_q400})
             + $signed({15'd0, r2_md}) + 24'(r_corr) + 24'(g2h_pkg::DN_BIAS);
        n3_t = 22'(sum3);

        n4_neg = r3_t[21];
        n4_mag = n4_neg ? 21'(-r3_t) : 21'(r3_t);

        n5_qc = 7'(g2h_pkg::mul_shr(32'(r4_mag), 32'(g2h_pkg::M_CYC), g2h_pkg::S_CYC));

        // truncating division: quotient and remainder take the dividend's sign
        rmag6   = 14'(r5_mag - 21'(r5_qc) * 21'(g2h_pkg::DIV_CYC));
        n6_cyc  = r5_neg ? -$signed({1'b0, r5_qc}) : $signed({1'b0, r5_qc});
        n6_rem2 = (r5_neg ? -$signed({1'b0, rmag6}) : $signed({1'b0, rmag6}))
                + 15'(g2h_pkg::CYCLE_OFS);

        n7_s    = r6_rem2[14];
        n7_rabs = n7_s ? 14'(-r6_rem2) : 14'(r6_rem2);
        n7_na1  = 15'(16'(g2h_pkg::YIN_A_OFS) - 16'(r6_rem2));
        n7_na2  = 20'(n7_rabs) * 20'(g2h_pkg::MUL_A2);
        n7_nb2  = 19'(n7_rabs) * 19'(g2h_pkg::MUL_B2);

        n8_qa1 = 2'(g2h_pkg::mul_shr(32'(r7_na1), 32'(g2h_pkg::M_A1), g2h_pkg::S_A1));
        n8_qa2 = 5'(g2h_pkg::mul_shr(32'(r7_na2), 32'(g2h_pkg::M_A2), g2h_pkg::S_A2));
        n8_qb1 = 1'(g2h_pkg::mul_shr(32'(r7_rabs), 32'(g2h_pkg::M_B1), g2h_pkg::S_B1));
        n8_qb2 = 5'(g2h_pkg::mul_shr(32'(r7_nb2), 32'(g2h_pkg::M_B2), g2h_pkg::S_B2));

        // second product has both factors of the same sign
        pa9    = 7'(r8_qa1) * 7'(r8_qa2);
        pb9    = r8_qb1 ? r8_qb2 : 5'd0;
        n9_yin = (r8_s ? -$signed({1'b0, pa9}) : $signed({1'b0, pa9}))
               + $signed({3'b000, pb9});

        n10_ys    = r9_yin[7];
        n10_yabs  = n10_ys ? 7'(-r9_yin) : 7'(r9_yin);
        c1v10     = 9'(g2h_pkg::C1_OFS) - 9'(r9_yin);
        n10_c1neg = c1v10[8];
        n10_nc1   = n10_c1neg ? 8'(-c1v10) : 8'(c1v10);
        n10_nc2   = 22'(n10_yabs) * 22'(g2h_pkg::MUL_C2);
        n10_nd2   = 21'(n10_yabs) * 21'(g2h_pkg::MUL_D2);
        n10_hy    = 12'(r9_cyc) * 12'(g2h_pkg::YEARS_CYCLE) + 12'(r9_yin)
                  - 12'(g2h_pkg::YEARS_CYCLE);

        n11_qc1 = 4'(g2h_pkg::mul_shr(32'(r10_nc1), 32'(g2h_pkg::M_C1), g2h_pkg::S_C1));
        n11_qc2 = 16'(g2h_pkg::mul_shr(32'(r10_nc2), 32'(g2h_pkg::M_C2), g2h_pkg::S_C2));
        n11_qd1 = 3'(g2h_pkg::mul_shr(32'(r10_yabs), 32'(g2h_pkg::M_D1), g2h_pkg::S_D1));
        n11_qd2 = 16'(g2h_pkg::mul_shr(32'(r10_nd2), 32'(g2h_pkg::M_D2), g2h_pkg::S_D2));

        n12_pc = 20'(r11_qc1) * 20'(r11_qc2);
        n12_pd = 19'(r11_qd1) * 19'(r11_qd2);

        n13_rem3 = 22'(r12_rem2)
                 - (r12_pcneg ? -$signed({2'b00, r12_pc}) : $signed({2'b00, r12_pc}))
                 - $signed({3'b000, r12_pd}) + 22'(g2h_pkg::MON_OFS);

        n14_mneg = r13_rem3[21];
        rabs14   = n14_mneg ? 21'(-r13_rem3) : 21'(r13_rem3);
        n14_nm   = 26'(rabs14) * 26'(g2h_pkg::MUL_MON);

        n15_qm = 17'(g2h_pkg::mul_shr(32'(r14_nm), 32'(g2h_pkg::M_MON), g2h_pkg::S_MON));

        // 709 * mon has the sign of mon, so work on the magnitude
        n16_ndd = 26'(r15_qm) * 26'(g2h_pkg::DIV_MON);
        n16_hm  = r15_mneg ? 4'(17'd0 - r15_qm) : 4'(r15_qm);

        n17_qdd = 22'(g2h_pkg::mul_shr(32'(r16_ndd), 32'(g2h_pkg::M_DAY), g2h_pkg::S_DAY));

        n_res.year  = r17_hy;
        n_res.month = r17_hm;
        n_res.day   = r17_rlo - (r17_mneg ? 5'(22'd0 - r17_qdd) : 5'(r17_qdd));
    end

    // output register plus one-entry skid; pipeline freezes only while skid holds
    always_comb begin
        adv           = !r_sk_v;
        take          = r_o_v && !i_stall;
        n_o_v         = r_o_v;
        n_sk_v        = r_sk_v;
        load_out      = 1'b0;
        load_skid     = 1'b0;
        out_from_skid = 1'b0;
        if (r_sk_v) begin
            if (take) begin
                n_o_v         = 1'b1;
                n_sk_v        = 1'b0;
                out_from_skid = 1'b1;
            end
        end else if (!r_o_v || take) begin
            n_o_v    = r_vld[NST];
            load_out = r_vld[NST];
        end else if (r_vld[NST]) begin
            n_sk_v    = 1'b1;
            load_skid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
            r_corr <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_corr <= i_cfg_wr_data;
            end
            if (adv) begin
                r_vld <= {r_vld[NST-1:1], i_valid};
            end
            r_o_v  <= n_o_v;
            r_sk_v <= n_sk_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= n_res;
        end else if (out_from_skid) begin
            r_out <= r_skid;
        end
        if (load_skid) begin
            r_skid <= n_res;
        end
        if (adv) begin
            r1_yy     <= n1_yy;
            r1_md     <= n1_md;
            r2_p365   <= n2_p365;
            r2_y4     <= n2_y4;
            r2_q100   <= n2_q100;
            r2_q400   <= n2_q400;
            r2_md     <= r1_md;
            r3_t      <= n3_t;
            r4_neg    <= n4_neg;
            r4_mag    <= n4_mag;
            r5_qc     <= n5_qc;
            r5_mag    <= r4_mag;
            r5_neg    <= r4_neg;
            r6_cyc    <= n6_cyc;
            r6_rem2   <= n6_rem2;
            r7_s      <= n7_s;
            r7_rabs   <= n7_rabs;
            r7_na1    <= n7_na1;
            r7_na2    <= n7_na2;
            r7_nb2    <= n7_nb2;
            r7_rem2   <= r6_rem2;
            r7_cyc    <= r6_cyc;
            r8_qa1    <= n8_qa1;
            r8_qa2    <= n8_qa2;
            r8_qb1    <= n8_qb1;
            r8_qb2    <= n8_qb2;
            r8_s      <= r7_s;
            r8_rem2   <= r7_rem2;
            r8_cyc    <= r7_cyc;
            r9_yin    <= n9_yin;
            r9_rem2   <= r8_rem2;
            r9_cyc    <= r8_cyc;
            r10_ys    <= n10_ys;
            r10_c1neg <= n10_c1neg;
            r10_yabs  <= n10_yabs;
            r10_nc1   <= n10_nc1;
            r10_nc2   <= n10_nc2;
            r10_nd2   <= n10_nd2;
            r10_hy    <= n10_hy;
            r10_rem2  <= r9_rem2;
            r11_qc1   <= n11_qc1;
            r11_qc2   <= n11_qc2;
            r11_qd1   <= n11_qd1;
            r11_qd2   <= n11_qd2;
            r11_pcneg <= r10_c1neg ^ r10_ys;
            r11_rem2  <= r10_rem2;
            r11_hy    <= r10_hy;
            r12_pc    <= n12_pc;
            r12_pd    <= n12_pd;
            r12_pcneg <= r11_pcneg;
            r12_rem2  <= r11_rem2;
            r12_hy    <= r11_hy;
            r13_rem3  <= n13_rem3;
            r13_hy    <= r12_hy;
            r14_mneg  <= n14_mneg;
            r14_nm    <= n14_nm;
            r14_rlo   <= r13_rem3[4:0];
            r14_hy    <= r13_hy;
            r15_qm    <= n15_qm;
            r15_mneg  <= r14_mneg;
            r15_rlo   <= r14_rlo;
            r15_hy    <= r14_hy;
            r16_ndd   <= n16_ndd;
            r16_hm    <= n16_hm;
            r16_mneg  <= r15_mneg;
            r16_rlo   <= r15_rlo;
            r16_hy    <= r15_hy;
            r17_qdd   <= n17_qdd;
            r17_hm    <= r16_hm;
            r17_mneg  <= r16_mneg;
            r17_rlo   <= r16_rlo;
            r17_hy    <= r16_hy;
        end
    end

    assign o_stall       = r_sk_v;
    assign o_valid       = r_o_v;
    assign o_hijri_year  = r_out.year;
    assign o_hijri_month = r_out.month;
    assign o_hijri_day   = r_out.day;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_o_v)
        else $error("skid holds a result while output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && i_stall && !r_sk_v && r_vld[NST]) |=> r_sk_v)
        else $error("result leaving pipeline during stall was not parked");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_v && i_stall) |=> (r_sk_v && $stable(r_skid)))
        else $error("parked result lost or changed during stall");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_v) |-> $past(r_vld[NST]))
        else $error("output became valid without a request at the last stage");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the Gregorian to tabular Hijri date converter.
module tb;

    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_DATES = 150;

    typedef enum logic [1:0] {
        REQ_DATE,
        REQ_SET_CORR,
        REQ_WAIT_IDLE
    } t_req_kind;

    typedef struct {
        t_req_kind         kind;
        logic [11:0]       year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic signed [5:0] corr;
    } t_date_req;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_BURSTS,
        STALL_RARE
    } t_stall_style;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic signed [5:0] i_cfg_wr_data = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [11:0]       i_greg_year = '0;
    logic [3:0]        i_greg_month = '0;
    logic [4:0]        i_greg_day = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [11:0]       o_hijri_year;
    logic [3:0]        o_hijri_month;
    logic [4:0]        o_hijri_day;

    t_date_req         date_reqs[$];
    g2h_pkg::t_hijri   hijri_due[$];
    logic signed [5:0] tb_day_corr = '0;

    int n_dates = 0;
    int n_odd_dates = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_settings = 0;
    int n_fail = 0;
    int quiet_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;

    logic              drv_valid;
    logic              drv_wr_en;
    t_date_req         cur_req;
    g2h_pkg::t_hijri   want;
    logic              stall_next;
    t_stall_style      stall_style = STALL_NONE;
    int                stall_span = 0;
    int                stall_run = 0;
    logic              stall_run_on = 1'b0;

    gregorian_to_hijri_date_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_greg_year   (i_greg_year),
        .i_greg_month  (i_greg_month),
        .i_greg_day    (i_greg_day),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hijri_year  (o_hijri_year),
        .o_hijri_month (o_hijri_month),
        .o_hijri_day   (o_hijri_day)
    );

    // Civil date -> day number -> 30-year tabular calendar, truncating division throughout
    function automatic g2h_pkg::t_hijri hijri_of(input logic [11:0] gy, input logic [3:0] gm,
                                                 input logic [4:0] gd,
                                                 input logic signed [5:0] corr);
        longint y, m, d, early, yy, mm, dn, rem, cycles, yin, mon;
        g2h_pkg::t_hijri r;
        y = gy;
        m = gm;
        d = gd;
        early = (14 - m) / 12;
        yy = y + 4800 - early;
        mm = m + 12 * early - 3;
        dn = d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045;
        dn = dn + longint'(corr);
        rem = dn - 1948440 + 10632;
        cycles = (rem - 1) / 10631;
        rem = rem - 10631 * cycles + 354;
        yin = ((10985 - rem) / 5316) * ((50 * rem) / 17719)
            + (rem / 5670) * ((43 * rem) / 15238);
        rem = rem - ((30 - yin) / 15) * ((17719 * yin) / 50)
            - (yin / 16) * ((15238 * yin) / 43) + 29;
        mon = (24 * rem) / 709;
        r.year  = 12'(30 * cycles + yin - 30);
        r.month = 4'(mon);
        r.day   = 5'(rem - (709 * mon) / 24);
        return r;
    endfunction

    task automatic add_date(input int y, input int m, input int d);
        t_date_req r;
        r.kind = REQ_DATE;
        r.year = 12'(y);
        r.month = 4'(m);
        r.day = 5'(d);
        r.corr = '0;
        date_reqs.push_back(r);
        n_dates++;
        if (y < 1600 || y > 4000 || m < 1 || m > 12 || d < 1)
            n_odd_dates++;
    endtask

    task automatic add_ctl(input t_req_kind kind, input logic signed [5:0] corr);
        t_date_req r;
        r.kind = kind;
        r.year = '0;
        r.month = '0;
        r.day = '0;
        r.corr = corr;
        date_reqs.push_back(r);
    endtask

    task automatic add_random_date();
        // mostly nominal dates, some anywhere the field widths allow
        if ($urandom_range(0, 6) == 0)
            add_date($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31));
        else
            add_date($urandom_range(1600, 4000), $urandom_range(1, 12), $urandom_range(1, 31));
    endtask

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sender: bursts of requests with random gaps; control entries wait for an idle block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_cfg_wr_en <= 1'b0;
        end else begin
            drv_valid = i_valid;
            drv_wr_en = 1'b0;
            if (i_valid && !o_stall) begin
                hijri_due.push_back(hijri_of(i_greg_year, i_greg_month, i_greg_day,
                                             tb_day_corr));
                n_accepted++;
                drv_valid = 1'b0;
            end
            if (!drv_valid && date_reqs.size() != 0) begin
                if (date_reqs[0].kind == REQ_DATE) begin
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 250)
                                                                 : $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        cur_req = date_reqs.pop_front();
                        i_greg_year <= cur_req.year;
                        i_greg_month <= cur_req.month;
                        i_greg_day <= cur_req.day;
                        drv_valid = 1'b1;
                        burst_left--;
                    end
                end else if (hijri_due.size() == 0) begin
                    cur_req = date_reqs.pop_front();
                    if (cur_req.kind == REQ_SET_CORR) begin
                        drv_wr_en = 1'b1;
                        i_cfg_wr_data <= cur_req.corr;
                        tb_day_corr = cur_req.corr;
                        n_settings++;
                    end
                end
            end
            i_valid <= drv_valid;
            i_cfg_wr_en <= drv_wr_en;
        end
    end

    // receiver stall pattern: a new style is picked whenever the current span runs out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_style = t_stall_style'($urandom_range(0, 3));
                stall_span = $urandom_range(50, 300);
            end
            stall_span--;
            case (stall_style)
                STALL_NONE: begin
                    stall_next = 1'b0;
                end
                STALL_RANDOM: begin
                    stall_next = ($urandom_range(0, 2) == 0);
                end
                STALL_BURSTS: begin
                    if (stall_run == 0) begin
                        stall_run_on = ~stall_run_on;
                        stall_run = stall_run_on ? $urandom_range(1, 20) : $urandom_range(1, 8);
                    end
                    stall_run--;
                    stall_next = stall_run_on;
                end
                default: begin
                    stall_next = ($urandom_range(0, 9) == 0);
                end
            endcase
            i_stall <= stall_next;
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (hijri_due.size() == 0) begin
                    $error("unexpected result %0d-%0d-%0d", o_hijri_year, o_hijri_month,
                           o_hijri_day);
                    n_fail++;
                end else begin
                    want = hijri_due.pop_front();
                    if (o_hijri_year !== want.year) begin
                        $error("hijri_year: expected %0d, got %0d", want.year, o_hijri_year);
                        n_fail++;
                    end
                    if (o_hijri_month !== want.month) begin
                        $error("hijri_month: expected %0d, got %0d", want.month,
                               o_hijri_month);
                        n_fail++;
                    end
                    if (o_hijri_day !== want.day) begin
                        $error("hijri_day: expected %0d, got %0d", want.day, o_hijri_day);
                        n_fail++;
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: no request or result for %0d cycles", QUIET_LIMIT);
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        logic signed [5:0] corr_pick;

        // directed: range edges, leap rules, month wrap, malformed fields
        add_date(1600, 1, 1);
        add_date(4000, 12, 31);
        add_date(2000, 2, 29);
        add_date(1900, 2, 29);
        add_date(2024, 2, 28);
        add_date(2024, 3, 1);
        add_date(1600, 3, 1);
        add_date(2100, 12, 31);
        add_date(2000, 0, 10);
        add_date(2000, 13, 1);
        add_date(2000, 15, 31);
        add_date(2000, 6, 0);
        add_date(0, 0, 0);
        add_date(4095, 15, 31);
        add_date(1, 1, 1);
        add_ctl(REQ_SET_CORR, 6'sd31);
        add_date(2023, 7, 19);
        add_date(1600, 1, 1);
        add_date(4000, 12, 31);
        add_ctl(REQ_SET_CORR, -6'sd32);
        add_date(2023, 7, 19);
        add_date(1600, 1, 1);
        add_date(4000, 12, 31);
        add_date(0, 1, 1);

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: corr_pick = 6'sd30;
                1: corr_pick = -6'sd30;
                2: corr_pick = 6'sd0;
                3: corr_pick = 6'sd31;
                4: corr_pick = -6'sd32;
                default: corr_pick = 6'($urandom_range(0, 63));
            endcase
            add_ctl(REQ_SET_CORR, corr_pick);
            for (int k = 0; k < PHASE_DATES; k++) begin
                // sender holds off mid-phase until the pipeline has emptied
                if (k == PHASE_DATES / 2 && p % 3 == 1)
                    add_ctl(REQ_WAIT_IDLE, '0);
                add_random_date();
            end
        end

        do @(negedge i_clk);
        while (n_accepted != n_dates || hijri_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (hijri_due.size() != 0) begin
            $error("%0d expected results never arrived", hijri_due.size());
            n_fail++;
        end
        $display("tb: %0d dates converted (%0d with out-of-range fields), %0d results seen",
                 n_accepted, n_odd_dates, n_results);
        $display("tb: %0d day-correction writes including both extremes", n_settings);
        if (n_fail == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
